FILE: design/rqf_pkg.sv
package rqf_pkg;

   typedef enum logic [1:0] {
      ACT_PUSH     = 2'd0,
      ACT_POP      = 2'd1,
      ACT_TAKE_MIN = 2'd2,
      ACT_CLEAR    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  task_id;
      logic [7:0]  priority_req;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_task_id;
      logic [7:0]  out_priority;
      status_type  status;
      logic [4:0]  count;
   } rsp_type;

   // One stored queue entry.
   typedef struct packed {
      logic [7:0]  id;
      logic [7:0]  pri;
   } entry_type;

endpackage

FILE: design/ready_queue_fifo_priority_extract.sv
// Task ready queue that keeps arrival order and can take out its most urgent entry.
// A request beat is taken at a rising edge where start is high and busy is low; its
// action pushes a task at the tail, pops the oldest task, removes the task with the
// smallest priority value (the oldest one on ties), or clears the queue.
// Every request produces exactly one response beat, shown on rsp_payload for one
// cycle while rsp_valid is high; the receiver cannot hold it off.
// Push, clear and a removal that finds the queue empty answer in the cycle after the
// request, and busy stays low, so these may be issued back to back.
// Pop and remove-highest run through one shared compare unit and the single read
// port of the entry memory: the scan reads the entries in order (a pop reads only
// the head), then the gap behind the removed slot is closed at one entry a cycle.
// The response beat shows in the first cycle that busy is low again.
// Reset empties the queue at once by clearing the fill count; the entry memory is
// not cleared, since only slots below the count are ever read.
module ready_queue_fifo_priority_extract #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rqf_pkg::req_type req_payload,
   output logic             busy,
   output logic             rsp_valid,
   output rqf_pkg::rsp_type rsp_payload
);

   import rqf_pkg::*;

   // Index into the memory, and a count that can also hold DEPTH itself.
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT
   } state_type;

   // Entry memory: one write and one registered read per cycle.
   entry_type mem [DEPTH];
   entry_type rd_ff;
   logic            rd_en;
   logic [IW-1:0]   rd_addr;
   logic            wr_en;
   logic [IW-1:0]   wr_addr;
   entry_type       wr_data;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   issue_ff, issue_in;
   logic [CW-1:0]   limit_ff, limit_in;
   logic            pend_ff, pend_in;
   logic [IW-1:0]   pend_idx_ff, pend_idx_in;
   logic [IW-1:0]   best_idx_ff, best_idx_in;
   entry_type       best_ff, best_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            accept;
   logic            take;

   assign accept = start && (state_ff == S_IDLE);

   // The shared compare: the entry just read replaces the best so far when it is the
   // first one of the scan or strictly more urgent, so the oldest one wins on ties.
   assign take = pend_ff && ((pend_idx_ff == '0) || (rd_ff.pri < best_ff.pri));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      limit_in     = limit_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = issue_ff[IW-1:0];
      wr_en        = 1'b0;
      wr_addr      = count_ff[IW-1:0];
      wr_data      = '{id: req_payload.task_id, pri: req_payload.priority_req};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in.out_task_id  = '0;
               rsp_in.out_priority = '0;
               rsp_in.status       = ST_OK;
               rsp_in.count        = 5'(count_ff);
               case (req_payload.action)
                  ACT_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        wr_en        = 1'b1;
                        count_in     = count_ff + 1'b1;
                        rsp_in.count = 5'(count_ff + 1'b1);
                     end
                  end
                  ACT_POP, ACT_TAKE_MIN: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        // A pop is a scan that stops after the head entry.
                        limit_in = (req_payload.action == ACT_POP) ? CW'(1) : count_ff;
                        issue_in = '0;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     count_in     = '0;
                     rsp_in.count = '0;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (issue_ff < limit_ff) begin
               rd_en       = 1'b1;
               issue_in    = issue_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IW-1:0];
            end
            if (take) begin
               best_in     = rd_ff;
               best_idx_in = pend_idx_ff;
            end
            // The last entry of the scan is compared in this cycle.
            if ((issue_ff >= limit_ff) && pend_ff) begin
               pend_in  = 1'b0;
               issue_in = CW'(take ? pend_idx_ff : best_idx_ff) + 1'b1;
               state_in = S_SHIFT;
            end
         end

         S_SHIFT: begin
            // Read slot i, then write it one place lower in the next cycle.
            if (issue_ff < count_ff) begin
               rd_en       = 1'b1;
               issue_in    = issue_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IW-1:0];
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff - 1'b1;
               wr_data = rd_ff;
            end
            if (issue_ff >= count_ff) begin
               pend_in             = 1'b0;
               count_in            = count_ff - 1'b1;
               rsp_valid_in        = 1'b1;
               rsp_in.out_task_id  = best_ff.id;
               rsp_in.out_priority = best_ff.pri;
               rsp_in.status       = ST_OK;
               rsp_in.count        = 5'(count_ff - 1'b1);
               state_in            = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issue_ff    <= issue_in;
      limit_ff    <= limit_in;
      pend_idx_ff <= pend_idx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: design/rqf_checker.sv
module rqf_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input rqf_pkg::req_type req_payload,
   input logic             busy,
   input logic             rsp_valid,
   input rqf_pkg::rsp_type rsp_payload
);

   import rqf_pkg::*;

   logic accept;
   assign accept = start && !busy;

   // A long operation always ends with its response beat.
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("busy fell without a response beat");

   // Push and clear answer at once and leave the block free.
   a_short_ops: assert property (@(posedge clock) disable iff (reset)
      accept && (req_payload.action == ACT_PUSH || req_payload.action == ACT_CLEAR)
      |=> rsp_valid && !busy)
      else $error("push or clear did not answer in the next cycle");

   // Pop and remove-highest either start working or report an empty queue.
   a_long_ops: assert property (@(posedge clock) disable iff (reset)
      accept && (req_payload.action == ACT_POP || req_payload.action == ACT_TAKE_MIN)
      |=> busy || (rsp_valid && rsp_payload.status == ST_EMPTY))
      else $error("removal neither started nor reported empty");

   // Clear leaves nothing in the queue.
   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.action == ACT_CLEAR |=> rsp_payload.count == '0)
      else $error("clear left entries in the queue");

endmodule

bind ready_queue_fifo_priority_extract rqf_checker u_rqf_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .req_payload (req_payload),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import rqf_pkg::*;

   // Queue depth of the block under test. The worst-case command is a remove-highest
   // on a full queue.
   localparam int QUEUE_DEPTH = 16;
   localparam int WORST_LATENCY = 2 * QUEUE_DEPTH + 4;

   // Scoreboard: keeps its own copy of the ready queue, works out the response
   // each accepted request must produce, and compares responses in order.
   class ready_queue_scoreboard;
      int unsigned capacity;
      logic [7:0]  held_ids[$];
      logic [7:0]  held_pris[$];
      rsp_type     awaited_rsps[$];
      int unsigned mismatches;
      int unsigned beats_checked;
      int unsigned full_pushes;
      int unsigned empty_removals;
      int unsigned min_removals;
      int unsigned deepest_fill;

      function new(int unsigned depth);
         capacity = depth;
         mismatches = 0;
         beats_checked = 0;
         full_pushes = 0;
         empty_removals = 0;
         min_removals = 0;
         deepest_fill = 0;
      endfunction

      function int unsigned pending();
         return awaited_rsps.size();
      endfunction

      // Applies one accepted request to the shadow queue and records the
      // response it must produce.
      function void note_request(req_type beat);
         rsp_type     want;
         int unsigned best;
         int unsigned i;
         want = '0;
         want.status = ST_OK;
         case (beat.action)
            ACT_PUSH: begin
               if (held_ids.size() >= capacity) begin
                  want.status = ST_FULL;
                  full_pushes++;
               end else begin
                  held_ids.push_back(beat.task_id);
                  held_pris.push_back(beat.priority_req);
               end
            end
            ACT_POP: begin
               if (held_ids.size() == 0) begin
                  want.status = ST_EMPTY;
                  empty_removals++;
               end else begin
                  want.out_task_id = held_ids.pop_front();
                  want.out_priority = held_pris.pop_front();
               end
            end
            ACT_TAKE_MIN: begin
               if (held_ids.size() == 0) begin
                  want.status = ST_EMPTY;
                  empty_removals++;
               end else begin
                  // Strict compare keeps the oldest entry on a tie.
                  best = 0;
                  for (i = 1; i < held_pris.size(); i++) begin
                     if (held_pris[i] < held_pris[best]) best = i;
                  end
                  want.out_task_id = held_ids[best];
                  want.out_priority = held_pris[best];
                  held_ids.delete(best);
                  held_pris.delete(best);
                  min_removals++;
               end
            end
            default: begin
               held_ids.delete();
               held_pris.delete();
            end
         endcase
         want.count = 5'(held_ids.size());
         if (held_ids.size() > deepest_fill) deepest_fill = held_ids.size();
         awaited_rsps.push_back(want);
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      // Checks one response beat against the oldest outstanding expectation.
      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited_rsps.size() == 0) begin
            $display("%0t ns: unexpected response, actual %p", $time, got);
            mismatches++;
            return;
         end
         want = awaited_rsps.pop_front();
         beats_checked++;
         compare_field("out_task_id", want.out_task_id, got.out_task_id);
         compare_field("out_priority", want.out_priority, got.out_priority);
         compare_field("status", 8'(want.status), 8'(got.status));
         compare_field("count", 8'(want.count), 8'(got.count));
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   req_type req_payload;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_payload;

   ready_queue_scoreboard queue_sb = new(QUEUE_DEPTH);

   ready_queue_fifo_priority_extract #(
      .DEPTH(QUEUE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_payload(req_payload),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

   // 10 ns clock with the first rising edge at 5 ns.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor. Everything here reads the values that were settled before the
   // edge, so a request beat is seen exactly when the block takes it and a
   // response beat exactly in the cycle its strobe is high.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) queue_sb.note_request(req_payload);
         if (rsp_valid) queue_sb.check_response(rsp_payload);
      end
   end

   function automatic req_type make_req(action_type act, logic [7:0] id, logic [7:0] pri);
      req_type beat;
      beat.action = act;
      beat.task_id = id;
      beat.priority_req = pri;
      return beat;
   endfunction

   // Offers one request beat, optionally after some idle cycles, and returns at
   // the edge where the block accepts it. Start is left high so that the next
   // beat can follow back to back; an idle cycle or wait_for_drain lowers it.
   task automatic send_request(input req_type beat, input int idle_pct);
      while ($urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Holds the sender off until every outstanding response has come back.
   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (queue_sb.pending() != 0) @(posedge clock);
   endtask

   // Random traffic. The push share swings between high and low every few dozen
   // beats, so the queue keeps filling to the top and draining to empty, which
   // is where the full and empty cases live. Half the priorities come from a
   // tiny range so that remove-highest often has to break a tie.
   task automatic run_random(input int n_items, input int idle_pct);
      req_type    beat;
      action_type act;
      int         push_pct;
      int         roll;
      int         n;
      for (n = 0; n < n_items; n++) begin
         push_pct = ((n / 32) % 2 == 0) ? 75 : 30;
         roll = $urandom_range(99, 0);
         if (roll < push_pct) act = ACT_PUSH;
         else if (roll < push_pct + (97 - push_pct) / 2) act = ACT_POP;
         else if (roll < 97) act = ACT_TAKE_MIN;
         else act = ACT_CLEAR;
         beat = make_req(act, 8'($urandom_range(255, 0)),
                         ($urandom_range(1, 0) == 1) ? 8'($urandom_range(255, 0))
                                                     : 8'($urandom_range(3, 0)));
         send_request(beat, idle_pct);
      end
   endtask

   initial begin
      int i;
      reset <= 1'b1;
      start <= 1'b0;
      req_payload <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: removals and clear on an empty queue, the field
      // extremes, an earliest-wins tie, then a fill to the top with a push
      // that must be dropped and a remove-highest across a full queue.
      send_request(make_req(ACT_POP, 8'h00, 8'h00), 0);
      send_request(make_req(ACT_TAKE_MIN, 8'hFF, 8'hFF), 0);
      send_request(make_req(ACT_CLEAR, 8'h00, 8'h00), 0);
      send_request(make_req(ACT_PUSH, 8'hFF, 8'hFF), 0);
      send_request(make_req(ACT_PUSH, 8'h00, 8'h00), 0);
      send_request(make_req(ACT_PUSH, 8'hA5, 8'h00), 0);
      send_request(make_req(ACT_TAKE_MIN, 8'h00, 8'h00), 0);
      send_request(make_req(ACT_CLEAR, 8'hFF, 8'hFF), 0);
      for (i = 0; i < QUEUE_DEPTH; i++) begin
         send_request(make_req(ACT_PUSH, 8'(i * 17), 8'((i * 7) % 5)), 0);
      end
      send_request(make_req(ACT_PUSH, 8'h5A, 8'hA5), 0);
      send_request(make_req(ACT_TAKE_MIN, 8'h00, 8'h00), 0);
      wait_for_drain();

      // Random part in three phases: back to back, a sender that idles about
      // half the time, and one that idles about a quarter of the time. The
      // receiver side has no stall to apply, since it cannot refuse a beat.
      run_random(170, 0);
      wait_for_drain();
      run_random(170, 48);
      wait_for_drain();
      run_random(170, 23);
      wait_for_drain();

      // Give any stray response time to show up before the verdict.
      repeat (WORST_LATENCY) @(posedge clock);

      $display("Checked %0d response beats: %0d pushes onto a full queue,",
               queue_sb.beats_checked, queue_sb.full_pushes);
      $display("%0d removals from empty, %0d remove-highest extractions, deepest fill %0d.",
               queue_sb.empty_removals, queue_sb.min_removals, queue_sb.deepest_fill);
      if (queue_sb.mismatches == 0 && queue_sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog. Even if every request were a slow remove-highest on a full queue,
   // a correct run would need only about 200 us plus sender gaps; this allows
   // many times that.
   initial begin
      #2_000_000;
      $display("Timeout with %0d responses outstanding", queue_sb.pending());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: sim.f
design/rqf_pkg.sv
design/ready_queue_fifo_priority_extract.sv
design/rqf_checker.sv
tb/testbench.sv
